### hw/rtl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Component and hue formats
  localparam int unsigned COMP_W   = 8;
  localparam int unsigned HUE_W    = 13;
  localparam longint unsigned COMP_MAX = (64'd1 << COMP_W) - 64'd1;

  // Hue geometry: 1/16 degree units, 60 degrees per sector
  localparam int unsigned SECTOR_SPAN = 960;
  localparam int unsigned FULL_TURN   = 5760;
  localparam int unsigned NUM_SECTORS = 6;
  localparam int unsigned SPAN_SHIFT  = 6;    // 960 = 64 * 15
  localparam int unsigned SPAN_ODD    = SECTOR_SPAN >> SPAN_SHIFT;
  localparam int unsigned FRAC_W      = $clog2(SECTOR_SPAN);
  localparam int unsigned SECT_W      = $clog2(NUM_SECTORS);

  // f * s product and the full-scale numerator M * 960
  localparam int unsigned FS_W     = FRAC_W + COMP_W;
  localparam longint unsigned FULL = COMP_MAX * SECTOR_SPAN;
  localparam int unsigned FULL_W   = $clog2(FULL + 1);

  // p path: floor(x / M) for x < 2^NUMP_W, by reciprocal multiply
  localparam int unsigned NUMP_W   = 2 * COMP_W;
  localparam int unsigned P_L      = $clog2(COMP_MAX);
  localparam int unsigned P_K      = NUMP_W + P_L;
  localparam longint unsigned P_M  = (64'd1 << P_K) / COMP_MAX + 64'd1;
  localparam int unsigned P_MW     = NUMP_W + 1;
  localparam int unsigned PP_W     = NUMP_W + P_MW;

  // q/t path: floor(x / (M*960)) = floor((x >> 6) / (M*15))
  localparam int unsigned NUMQ_W   = FULL_W + COMP_W;
  localparam int unsigned SHQ_W    = NUMQ_W - SPAN_SHIFT;
  localparam longint unsigned Q_DIV = COMP_MAX * SPAN_ODD;
  localparam int unsigned Q_L      = $clog2(Q_DIV);
  localparam int unsigned Q_K      = SHQ_W + Q_L;
  localparam longint unsigned Q_M  = (64'd1 << Q_K) / Q_DIV + 64'd1;
  localparam int unsigned Q_MW     = SHQ_W + 1;
  localparam int unsigned QP_W     = SHQ_W + Q_MW;

  // Stream packing
  localparam int unsigned IN_W  = ((HUE_W + 2 * COMP_W + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((3 * COMP_W + 7) / 8) * 8;

  typedef enum logic [SECT_W-1:0] {
    SECT_R_Y = 3'd0,
    SECT_Y_G = 3'd1,
    SECT_G_C = 3'd2,
    SECT_C_B = 3'd3,
    SECT_B_M = 3'd4,
    SECT_M_R = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e               idx;
    logic [FRAC_W-1:0]     frac;
  } sect_t;

endpackage

### hw/rtl/hsv2rgb_sector.sv
`timescale 1ns / 1ps

// Hue wrap, 60-degree sector index and position within the sector.
module hsv2rgb_sector (
  input  logic [hsv2rgb_pkg::HUE_W-1:0] hue_i,
  output hsv2rgb_pkg::sect_t            sect_o
);
  import hsv2rgb_pkg::*;

  logic [HUE_W-1:0] hue_wrap;
  logic [HUE_W-1:0] base;
  sector_e          idx;

  always_comb begin
    if (hue_i >= HUE_W'(FULL_TURN)) begin
      hue_wrap = hue_i - HUE_W'(FULL_TURN);
    end else begin
      hue_wrap = hue_i;
    end
    idx  = SECT_R_Y;
    base = '0;
    // independent threshold compares, highest passing one wins
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (hue_wrap >= HUE_W'(k * SECTOR_SPAN)) begin
        idx  = sector_e'(SECT_W'(k));
        base = HUE_W'(k * SECTOR_SPAN);
      end
    end
    sect_o.idx  = idx;
    sect_o.frac = FRAC_W'(hue_wrap - base);
  end

endmodule

### hw/rtl/hsv_to_rgb_top.sv
`timescale 1ns / 1ps

// HSV to RGB pixel converter. Takes one pixel per clock on the slave stream
// (hue in 1/16 degree, wrapped once if at or above 360 degrees; saturation and
// value as 8-bit fractions, 255 = 1.0) and returns one RGB pixel per request on
// the master stream. The pipeline stages, from input request to output valid, are:
// sector split, the two f*s products, the numerator multiplies, the reciprocal
// multiplies that replace the divisions by M and M*960, and the sector
// placement into the output register. Every stage has its own valid bit and a
// stage loads when it is empty or the stage after it moves, so bubbles close up
// and the input keeps taking pixels into empty stages while a finished result
// waits at the output. Sustained rate is one pixel per cycle as long as the
// sink takes one per cycle. Results are exact truncating fixed-point p, q and t.
module hsv_to_rgb_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave stream, tdata fields from bit 0: hue[13], saturation[8], brightness[8], pad
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [hsv2rgb_pkg::IN_W-1:0]  s_axis_tdata_i,
  // master stream, tdata fields from bit 0: red[8], green[8], blue[8]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [hsv2rgb_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import hsv2rgb_pkg::*;

  // Input field unpack
  logic [HUE_W-1:0]  in_hue;
  logic [COMP_W-1:0] in_sat;
  logic [COMP_W-1:0] in_val;
  sect_t             in_sect;

  assign in_hue = s_axis_tdata_i[HUE_W-1:0];
  assign in_sat = s_axis_tdata_i[HUE_W +: COMP_W];
  assign in_val = s_axis_tdata_i[HUE_W+COMP_W +: COMP_W];

  hsv2rgb_sector u_sector (
    .hue_i  (in_hue),
    .sect_o (in_sect)
  );

  // Per-stage valid bits and load enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic ld1, ld2, ld3, ld4, ld5;

  assign ld5 = !v5_q || m_axis_tready_i;
  assign ld4 = !v4_q || ld5;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;

  assign s_axis_tready_o = ld1;
  assign m_axis_tvalid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= s_axis_tvalid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
      if (ld5) v5_q <= v4_q;
    end
  end

  // Stage 1: sector and fraction
  sect_t             sect1_q;
  logic [COMP_W-1:0] sat1_q;
  logic [COMP_W-1:0] val1_q;

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      sect1_q <= in_sect;
      sat1_q  <= in_sat;
      val1_q  <= in_val;
    end
  end

  // Stage 2: f*s, (960-f)*s and the p numerator v*(M-s)
  logic [FRAC_W-1:0] frac_c;
  logic [COMP_W-1:0] sat_c;
  logic [FS_W-1:0]   fs_d, fcs_d, fs_q, fcs_q;
  logic [NUMP_W-1:0] nump_d, nump_q;
  sector_e           sect2_q;
  logic [COMP_W-1:0] val2_q;

  always_comb begin
    frac_c = FRAC_W'(SECTOR_SPAN) - sect1_q.frac;
    sat_c  = COMP_W'(COMP_MAX) - sat1_q;
    fs_d   = FS_W'(sect1_q.frac) * FS_W'(sat1_q);
    fcs_d  = FS_W'(frac_c) * FS_W'(sat1_q);
    nump_d = NUMP_W'(val1_q) * NUMP_W'(sat_c);
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      fs_q    <= fs_d;
      fcs_q   <= fcs_d;
      nump_q  <= nump_d;
      sect2_q <= sect1_q.idx;
      val2_q  <= val1_q;
    end
  end

  // Stage 3: q/t numerators v*(M*960 - ...), p reciprocal product
  logic [FULL_W-1:0] nq_c, nt_c;
  logic [NUMQ_W-1:0] numq_d, numt_d, numq_q, numt_q;
  logic [PP_W-1:0]   pm_d, pm_q;
  sector_e           sect3_q;
  logic [COMP_W-1:0] val3_q;

  always_comb begin
    nq_c   = FULL_W'(FULL) - FULL_W'(fs_q);
    nt_c   = FULL_W'(FULL) - FULL_W'(fcs_q);
    numq_d = NUMQ_W'(val2_q) * NUMQ_W'(nq_c);
    numt_d = NUMQ_W'(val2_q) * NUMQ_W'(nt_c);
    pm_d   = PP_W'(nump_q) * PP_W'(P_M);
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      numq_q  <= numq_d;
      numt_q  <= numt_d;
      pm_q    <= pm_d;
      sect3_q <= sect2_q;
      val3_q  <= val2_q;
    end
  end

  // Stage 4: q/t reciprocal products, p quotient
  logic [QP_W-1:0]   qm_d, tm_d, qm_q, tm_q;
  logic [COMP_W-1:0] p4_q;
  sector_e           sect4_q;
  logic [COMP_W-1:0] val4_q;

  always_comb begin
    qm_d = QP_W'(numq_q[NUMQ_W-1:SPAN_SHIFT]) * QP_W'(Q_M);
    tm_d = QP_W'(numt_q[NUMQ_W-1:SPAN_SHIFT]) * QP_W'(Q_M);
  end

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      qm_q    <= qm_d;
      tm_q    <= tm_d;
      p4_q    <= pm_q[P_K +: COMP_W];
      sect4_q <= sect3_q;
      val4_q  <= val3_q;
    end
  end

  // Stage 5: sector placement into the output register
  logic [COMP_W-1:0] q_c, t_c;
  logic [COMP_W-1:0] red_d, green_d, blue_d;
  logic [COMP_W-1:0] red_q, green_q, blue_q;

  always_comb begin
    q_c = qm_q[Q_K +: COMP_W];
    t_c = tm_q[Q_K +: COMP_W];
    case (sect4_q)
      SECT_R_Y: begin
        red_d = val4_q; green_d = t_c;    blue_d = p4_q;
      end
      SECT_Y_G: begin
        red_d = q_c;    green_d = val4_q; blue_d = p4_q;
      end
      SECT_G_C: begin
        red_d = p4_q;   green_d = val4_q; blue_d = t_c;
      end
      SECT_C_B: begin
        red_d = p4_q;   green_d = q_c;    blue_d = val4_q;
      end
      SECT_B_M: begin
        red_d = t_c;    green_d = p4_q;   blue_d = val4_q;
      end
      default: begin
        red_d = val4_q; green_d = p4_q;   blue_d = q_c;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld5) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign m_axis_tdata_o = OUT_W'({blue_q, green_q, red_q});

endmodule

### dv/hsv_to_rgb_checker.sv
`timescale 1ns / 1ps

// Watches both streams, predicts each RGB pixel from the accepted HSV request
// and compares it with what the converter returns, in order.
module hsv_to_rgb_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [hsv2rgb_pkg::IN_W-1:0]    s_tdata_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [hsv2rgb_pkg::OUT_W-1:0]   m_tdata_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  import hsv2rgb_pkg::*;

  // expected-pixel ring, far deeper than the pipeline
  localparam int unsigned EXP_DEPTH = 64;
  localparam int unsigned EXP_AW    = $clog2(EXP_DEPTH);

  // red in the low byte, as on m_axis_tdata
  typedef struct packed {
    logic [COMP_W-1:0] blue;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] red;
  } rgb_t;

  string comp_name [3] = '{"red", "green", "blue"};

  rgb_t              exp_mem [EXP_DEPTH];
  logic [EXP_AW-1:0] exp_wr_ptr = '0;
  logic [EXP_AW-1:0] exp_rd_ptr = '0;
  int unsigned       exp_cnt = 0;

  function automatic rgb_t hsv_pixel_to_rgb(logic [HUE_W-1:0] hue, logic [COMP_W-1:0] sat,
                                            logic [COMP_W-1:0] val);
    longint unsigned h, s, v, f, full, p, q, t;
    sector_e         sect;
    rgb_t            px;
    h = hue;
    s = sat;
    v = val;
    // one wrap brings codes at or above a full turn back into range
    if (h >= FULL_TURN) h = h - FULL_TURN;
    sect = sector_e'(SECT_W'(h / SECTOR_SPAN));
    f    = h % SECTOR_SPAN;
    full = COMP_MAX * SECTOR_SPAN;
    p = (v * (COMP_MAX - s)) / COMP_MAX;
    q = (v * (full - f * s)) / full;
    t = (v * (full - (SECTOR_SPAN - f) * s)) / full;
    case (sect)
      SECT_R_Y: px = '{blue: p[COMP_W-1:0], green: t[COMP_W-1:0], red: v[COMP_W-1:0]};
      SECT_Y_G: px = '{blue: p[COMP_W-1:0], green: v[COMP_W-1:0], red: q[COMP_W-1:0]};
      SECT_G_C: px = '{blue: t[COMP_W-1:0], green: v[COMP_W-1:0], red: p[COMP_W-1:0]};
      SECT_C_B: px = '{blue: v[COMP_W-1:0], green: q[COMP_W-1:0], red: p[COMP_W-1:0]};
      SECT_B_M: px = '{blue: v[COMP_W-1:0], green: p[COMP_W-1:0], red: t[COMP_W-1:0]};
      default:  px = '{blue: q[COMP_W-1:0], green: p[COMP_W-1:0], red: v[COMP_W-1:0]};
    endcase
    return px;
  endfunction

  always @(posedge clk_i) begin
    int unsigned errs;
    rgb_t        got;
    rgb_t        want;
    errs = 0;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        got = rgb_t'(m_tdata_i[3*COMP_W-1:0]);
        if (exp_cnt == 0) begin
          $display("%0t: pixel with nothing pending: r=%0d g=%0d b=%0d",
                   $time, got.red, got.green, got.blue);
          errs++;
        end else begin
          want       = exp_mem[exp_rd_ptr];
          exp_rd_ptr = exp_rd_ptr + 1'b1;
          exp_cnt--;
          for (int c = 0; c < 3; c++) begin
            if (got[c*COMP_W +: COMP_W] !== want[c*COMP_W +: COMP_W]) begin
              $display("%0t: %s mismatch: expected %0d, got %0d", $time, comp_name[c],
                       want[c*COMP_W +: COMP_W], got[c*COMP_W +: COMP_W]);
              errs++;
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (exp_cnt == EXP_DEPTH) begin
          $display("%0t: more than %0d pixels outstanding", $time, EXP_DEPTH);
          errs++;
        end else begin
          exp_mem[exp_wr_ptr] = hsv_pixel_to_rgb(s_tdata_i[HUE_W-1:0],
                                                 s_tdata_i[HUE_W +: COMP_W],
                                                 s_tdata_i[HUE_W+COMP_W +: COMP_W]);
          exp_wr_ptr = exp_wr_ptr + 1'b1;
          exp_cnt++;
        end
      end
    end
    fail_count_o <= fail_count_o + errs;
    pending_o    <= exp_cnt;
  end

endmodule

### dv/hsv_to_rgb_top_tb.sv
`timescale 1ns / 1ps

module hsv_to_rgb_top_tb;
  import hsv2rgb_pkg::*;

  // cycles with no accepted request on either stream before the run is called hung
  localparam int unsigned HANG_LIMIT = 1000;
  // random pixels per gap/stall phase
  localparam int unsigned PHASE_PIXELS = 463;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;

  // all converter inputs known from time zero
  logic             s_tvalid = 1'b0;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tready = 1'b0;
  logic             s_tready;
  logic             m_tvalid;
  logic [OUT_W-1:0] m_tdata;

  int unsigned      fail_count;
  int unsigned      pending;
  int unsigned      hang_cycles = 0;

  // chance in percent that the source inserts a gap / the sink stalls
  int unsigned      send_gap_pct = 0;
  int unsigned      sink_stall_pct = 0;

  always #1 clk_i = ~clk_i;

  hsv_to_rgb_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  hsv_to_rgb_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Sink: random backpressure, redrawn every cycle
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: any accepted request on either side restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        hang_cycles <= 0;
      end else if (hang_cycles >= HANG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        hang_cycles <= hang_cycles + 1;
      end
    end
  end

  // Present one HSV request, after a random number of idle cycles, and hold
  // it until the converter takes it. Valid stays high into the next call
  // when no gap is drawn, so back-to-back requests run at full rate.
  task automatic send_pixel(logic [HUE_W-1:0] hue, logic [COMP_W-1:0] sat,
                            logic [COMP_W-1:0] val);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W-HUE_W-2*COMP_W){1'b0}}, val, sat, hue};
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Stop sending and wait for every predicted pixel to come out. The extra
  // edge lets the checker count the request accepted last.
  task automatic drain_pixels();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly nominal hue, an eighth of it in the wrap range; components hit
  // both ends now and then.
  function automatic logic [HUE_W-1:0] pick_hue();
    if ($urandom_range(7) == 0) return HUE_W'($urandom_range(8191, FULL_TURN));
    return HUE_W'($urandom_range(FULL_TURN - 1));
  endfunction

  function automatic logic [COMP_W-1:0] pick_comp();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return COMP_W'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int unsigned gap_by_phase [4];
    int unsigned stall_by_phase [4];
    gap_by_phase   = '{0, 53, 0, 26};
    stall_by_phase = '{0, 0, 53, 26};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: sector edges, the wrap range, gray, black, full scale
    send_pixel(13'd0,    8'd255, 8'd255);  // pure red
    send_pixel(13'd959,  8'd255, 8'd255);  // last fraction of first sector
    send_pixel(13'd960,  8'd255, 8'd255);
    send_pixel(13'd1920, 8'd255, 8'd255);
    send_pixel(13'd2880, 8'd255, 8'd255);
    send_pixel(13'd3840, 8'd255, 8'd255);
    send_pixel(13'd4800, 8'd255, 8'd255);
    send_pixel(13'd5759, 8'd255, 8'd255);  // just below a full turn
    send_pixel(13'd5760, 8'd255, 8'd255);  // wraps to zero
    send_pixel(13'd6719, 8'd200, 8'd180);  // wraps to end of first sector
    send_pixel(13'd8191, 8'd255, 8'd255);  // largest code
    send_pixel(13'd4096, 8'd128, 8'd127);
    send_pixel(13'd1500, 8'd0,   8'd255);  // gray: all channels = value
    send_pixel(13'd3000, 8'd0,   8'd77);
    send_pixel(13'd2500, 8'd255, 8'd0);    // black regardless of hue
    send_pixel(13'd0,    8'd0,   8'd0);
    send_pixel(13'd480,  8'd255, 8'd255);
    send_pixel(13'd2400, 8'd1,   8'd254);
    send_pixel(13'd3360, 8'd254, 8'd1);
    send_pixel(13'd5280, 8'd170, 8'd85);
    send_pixel(13'd7000, 8'd85,  8'd170);

    // hold off until the pipeline is empty, then go at it again
    drain_pixels();

    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct   = gap_by_phase[ph];
      sink_stall_pct = stall_by_phase[ph];
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        send_pixel(pick_hue(), pick_comp(), pick_comp());
      end
    end

    drain_pixels();
    // then catch any stray output before the verdict
    repeat (20) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
